>>> rtl/core/abts_pkg.sv
package abts_pkg;

   localparam int TREE_SLOTS = 127;
   localparam int DATA_WIDTH = 16;
   localparam int SLOT_W     = $clog2(TREE_SLOTS);
   localparam int ADDR_W     = SLOT_W + 1;
   localparam int DEPTH_W    = 3;
   localparam int FETCH_N    = 5;
   localparam int FETCH_W    = $clog2(FETCH_N);
   localparam int REQ_W      = 48;
   localparam int RSP_W      = 120;

   // fetch slots: assign uses parent and children, read uses the first, find uses all
   localparam logic [SLOT_W-1:0] F_PARENT = SLOT_W'(0);
   localparam logic [SLOT_W-1:0] F_LCHILD = SLOT_W'(1);
   localparam logic [SLOT_W-1:0] F_RCHILD = SLOT_W'(2);
   localparam logic [SLOT_W-1:0] F_LSIB   = SLOT_W'(3);
   localparam logic [SLOT_W-1:0] F_RSIB   = SLOT_W'(4);

   typedef enum logic [1:0] {
      CMD_ASSIGN,
      CMD_READ,
      CMD_FIND,
      CMD_CLEAR
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_FETCH_WAIT,
      ST_WRITE,
      ST_SCAN,
      ST_SCAN_WAIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic              idle;
      logic              issue;
      logic              scan;
      logic [SLOT_W-1:0] tag;
      logic              write;
      logic              load_out;
   } ctl_type;

   typedef struct packed {
      logic [3:0]            pad;
      logic [DATA_WIDTH-1:0] search_key;
      logic [DATA_WIDTH-1:0] new_value;
      logic [6:0]            node_order;
      logic [2:0]            node_level;
      logic [1:0]            command;
   } req_type;

   typedef struct packed {
      logic [2:0]            pad;
      logic [DATA_WIDTH-1:0] root_value;
      logic [DEPTH_W-1:0]    tree_depth;
      logic                  tree_empty;
      logic [DATA_WIDTH-1:0] right_sibling_value;
      logic [DATA_WIDTH-1:0] left_sibling_value;
      logic [DATA_WIDTH-1:0] right_child_value;
      logic [DATA_WIDTH-1:0] left_child_value;
      logic [DATA_WIDTH-1:0] parent_value;
      logic [DATA_WIDTH-1:0] read_value;
      logic                  status;
   } rsp_type;

   function automatic logic [SLOT_W-1:0] fetch_last(input cmd_type cmd);
      logic [SLOT_W-1:0] r;
      case (cmd)
         CMD_ASSIGN: r = F_RCHILD;
         CMD_FIND:   r = F_RSIB;
         default:    r = F_PARENT;
      endcase
      return r;
   endfunction

   function automatic logic [DEPTH_W-1:0] bit_length(input logic [ADDR_W-1:0] n);
      logic [DEPTH_W-1:0] d;
      d = '0;
      for (int i = 0; i < ADDR_W; i++) begin
         if (n[i]) begin
            d = (i >= 7) ? DEPTH_W'(7) : DEPTH_W'(i + 1);
         end
      end
      return d;
   endfunction

endpackage

>>> rtl/core/array_binary_tree_store_unit.sv
// Binary tree store kept as an implicit heap-ordered slot array (127 slots,
// 16-bit values, 0 = empty node).
// req channel: one beat carries a command (assign, read, find, clear) with a
// (level, order) position, a new value and a search key.
// rsp channel: exactly one beat per request beat with status, read value,
// relatives of the key, root value, empty flag and tree depth.
// Order of work after the accepting edge: every command runs a
// one-slot-per-cycle sweep of the slot RAM (all 127 slots, then a drain state
// for the registered read) that yields depth, root and key matches, and ends
// with a load of the output register. Assign first reads parent and children,
// drains and writes; read first reads its slot and drains; find reads its five
// relatives and drains after the sweep; clear and bad positions do only the
// sweep. One request is in flight; req_tready is high only when idle, in the
// cycle after the load, so a new beat is taken only once the last is done.
// Reset clears all per-slot valid flags at once, so the tree is empty in the
// next cycle; clear does the same when its beat is accepted.
// A result waits in the output register while rsp_tready is low; the next
// request is taken meanwhile and its result is held until the slot frees.
module array_binary_tree_store_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // command[1:0], node_level[4:2], node_order[11:5], new_value[27:12],
   // search_key[43:28], zero pad
   input  abts_pkg::req_type req_tdata,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // status[0], read_value[16:1], parent_value[32:17], left_child_value[48:33],
   // right_child_value[64:49], left_sibling_value[80:65],
   // right_sibling_value[96:81], tree_empty[97], tree_depth[100:98],
   // root_value[116:101], zero pad
   output abts_pkg::rsp_type rsp_tdata
);
   import abts_pkg::*;

   ctl_type               ctl;
   logic                  req_fire;
   logic                  rsp_free;
   cmd_type               req_cmd;
   logic [ADDR_W-1:0]     pos_base;
   logic [ADDR_W-1:0]     pos_slot;
   logic                  pos_ok;

   cmd_type               cmd_ff, cmd_in;
   logic [SLOT_W-1:0]     idx_ff, idx_in;
   logic [DATA_WIDTH-1:0] val_ff, val_in;
   logic [DATA_WIDTH-1:0] key_ff, key_in;
   logic                  status_ff, status_in;
   logic [TREE_SLOTS-1:0] valid_ff, valid_in;

   logic                  pend_ff, pend_in;
   logic                  pend_scan_ff, pend_scan_in;
   logic [SLOT_W-1:0]     pend_tag_ff, pend_tag_in;
   logic                  pend_oor_ff, pend_oor_in;
   logic                  vld_q_ff, vld_q_in;

   logic [DATA_WIDTH-1:0] fv_ff [FETCH_N];
   logic [DATA_WIDTH-1:0] fv_in [FETCH_N];
   logic [DATA_WIDTH-1:0] root_ff, root_in;
   logic                  nz_ff, nz_in;
   logic [SLOT_W-1:0]     last_ff, last_in;
   logic                  has_any_ff, has_any_in;
   logic [SLOT_W-1:0]     m_any_ff, m_any_in;
   logic                  has_par_ff, has_par_in;
   logic [SLOT_W-1:0]     m_par_ff, m_par_in;
   logic                  has_even_ff, has_even_in;
   logic [SLOT_W-1:0]     m_even_ff, m_even_in;
   logic                  has_odd_ff, has_odd_in;
   logic [SLOT_W-1:0]     m_odd_ff, m_odd_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic [ADDR_W-1:0]     fa;
   logic                  fmiss;
   logic                  fetch_oor;
   logic [SLOT_W-1:0]     rd_addr;
   logic [DATA_WIDTH-1:0] ram_q;
   logic [DATA_WIDTH-1:0] rdata;
   logic                  wr_err;
   logic                  wr_en;

   assign req_tready = ctl.idle;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_cmd    = cmd_type'(req_tdata.command);

   // (level, order) -> slot 2^(level-1) + order - 2
   always_comb begin
      pos_base = ADDR_W'(1) << (req_tdata.node_level - 3'd1);
      pos_slot = pos_base + {1'b0, req_tdata.node_order} - ADDR_W'(2);
      pos_ok   = (req_tdata.node_level != '0) && (req_tdata.node_order != '0) &&
                 ({1'b0, req_tdata.node_order} <= pos_base) &&
                 (pos_slot < ADDR_W'(TREE_SLOTS));
   end

   abts_fsm u_fsm (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .req_cmd  (req_cmd),
      .cmd      (cmd_ff),
      .pos_ok   (pos_ok),
      .rsp_free (rsp_free),
      .ctl      (ctl)
   );

   // relative slot addresses
   always_comb begin
      fa    = '0;
      fmiss = 1'b1;
      case (cmd_ff)
         CMD_ASSIGN: begin
            case (ctl.tag)
               F_PARENT: begin
                  fa    = ({1'b0, idx_ff} - ADDR_W'(1)) >> 1;
                  fmiss = (idx_ff == '0);
               end
               F_LCHILD: begin
                  fa    = {idx_ff, 1'b1};
                  fmiss = 1'b0;
               end
               F_RCHILD: begin
                  fa    = {idx_ff, 1'b1} + ADDR_W'(1);
                  fmiss = 1'b0;
               end
               default: ;
            endcase
         end
         CMD_READ: begin
            fa    = {1'b0, idx_ff};
            fmiss = 1'b0;
         end
         CMD_FIND: begin
            case (ctl.tag)
               F_PARENT: begin
                  fa    = ({1'b0, m_par_ff} - ADDR_W'(1)) >> 1;
                  fmiss = !has_par_ff;
               end
               F_LCHILD: begin
                  fa    = {m_any_ff, 1'b1};
                  fmiss = !has_any_ff;
               end
               F_RCHILD: begin
                  fa    = {m_any_ff, 1'b1} + ADDR_W'(1);
                  fmiss = !has_any_ff;
               end
               F_LSIB: begin
                  fa    = {1'b0, m_even_ff} - ADDR_W'(1);
                  fmiss = !has_even_ff;
               end
               F_RSIB: begin
                  fa    = {1'b0, m_odd_ff} + ADDR_W'(1);
                  fmiss = !has_odd_ff;
               end
               default: ;
            endcase
            if (root_ff == '0) begin
               fmiss = 1'b1;
            end
         end
         default: ;
      endcase
   end

   assign fetch_oor = fmiss || (fa >= ADDR_W'(TREE_SLOTS));
   assign rd_addr   = ctl.scan ? ctl.tag : fa[SLOT_W-1:0];
   assign rdata     = (vld_q_ff && !pend_oor_ff) ? ram_q : '0;

   assign wr_err = ((val_ff != '0) && (idx_ff != '0) && (fv_ff[F_PARENT[FETCH_W-1:0]] == '0)) ||
                   ((val_ff == '0) && ((fv_ff[F_LCHILD[FETCH_W-1:0]] != '0) ||
                                       (fv_ff[F_RCHILD[FETCH_W-1:0]] != '0)));
   assign wr_en  = ctl.write && !wr_err;

   abts_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (TREE_SLOTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (idx_ff),
      .wr_data (val_ff),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   assign pend_in      = ctl.issue;
   assign pend_scan_in = ctl.scan;
   assign pend_tag_in  = ctl.tag;
   assign pend_oor_in  = !ctl.scan && fetch_oor;
   assign vld_q_in     = valid_ff[rd_addr];

   always_comb begin
      cmd_in      = cmd_ff;
      idx_in      = idx_ff;
      val_in      = val_ff;
      key_in      = key_ff;
      status_in   = status_ff;
      valid_in    = valid_ff;
      fv_in       = fv_ff;
      root_in     = root_ff;
      nz_in       = nz_ff;
      last_in     = last_ff;
      has_any_in  = has_any_ff;
      m_any_in    = m_any_ff;
      has_par_in  = has_par_ff;
      m_par_in    = m_par_ff;
      has_even_in = has_even_ff;
      m_even_in   = m_even_ff;
      has_odd_in  = has_odd_ff;
      m_odd_in    = m_odd_ff;

      if (req_fire) begin
         cmd_in      = req_cmd;
         idx_in      = pos_slot[SLOT_W-1:0];
         val_in      = req_tdata.new_value;
         key_in      = req_tdata.search_key;
         status_in   = (((req_cmd == CMD_ASSIGN) || (req_cmd == CMD_READ)) && !pos_ok) ||
                       ((req_cmd == CMD_FIND) && (req_tdata.search_key == '0));
         root_in     = '0;
         nz_in       = 1'b0;
         last_in     = '0;
         has_any_in  = 1'b0;
         has_par_in  = 1'b0;
         has_even_in = 1'b0;
         has_odd_in  = 1'b0;
         if (req_cmd == CMD_CLEAR) begin
            valid_in = '0;
         end
      end

      if (ctl.write) begin
         if (wr_err) begin
            status_in = 1'b1;
         end else begin
            valid_in[idx_ff] = 1'b1;
         end
      end

      if (pend_ff) begin
         if (pend_scan_ff) begin
            if (rdata != '0) begin
               nz_in   = 1'b1;
               last_in = pend_tag_ff;
            end
            if (pend_tag_ff == '0) begin
               root_in = rdata;
            end
            if ((key_ff != '0) && (rdata == key_ff)) begin
               if (!has_any_ff) begin
                  has_any_in = 1'b1;
                  m_any_in   = pend_tag_ff;
               end
               if ((pend_tag_ff != '0) && !has_par_ff) begin
                  has_par_in = 1'b1;
                  m_par_in   = pend_tag_ff;
               end
               if ((pend_tag_ff != '0) && !pend_tag_ff[0] && !has_even_ff) begin
                  has_even_in = 1'b1;
                  m_even_in   = pend_tag_ff;
               end
               if (pend_tag_ff[0] && !has_odd_ff) begin
                  has_odd_in = 1'b1;
                  m_odd_in   = pend_tag_ff;
               end
            end
         end else if (pend_tag_ff < SLOT_W'(FETCH_N)) begin
            fv_in[pend_tag_ff[FETCH_W-1:0]] = rdata;
         end
      end
   end

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (ctl.load_out) begin
         rsp_data_in            = '0;
         rsp_data_in.status     = status_ff;
         if ((cmd_ff == CMD_READ) && !status_ff) begin
            rsp_data_in.read_value = fv_ff[F_PARENT[FETCH_W-1:0]];
         end
         if (cmd_ff == CMD_FIND) begin
            rsp_data_in.parent_value        = fv_ff[F_PARENT[FETCH_W-1:0]];
            rsp_data_in.left_child_value    = fv_ff[F_LCHILD[FETCH_W-1:0]];
            rsp_data_in.right_child_value   = fv_ff[F_RCHILD[FETCH_W-1:0]];
            rsp_data_in.left_sibling_value  = fv_ff[F_LSIB[FETCH_W-1:0]];
            rsp_data_in.right_sibling_value = fv_ff[F_RSIB[FETCH_W-1:0]];
         end
         rsp_data_in.tree_empty = (root_ff == '0);
         rsp_data_in.tree_depth = nz_ff ? bit_length({1'b0, last_ff} + ADDR_W'(1)) : '0;
         rsp_data_in.root_value = root_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      idx_ff       <= idx_in;
      val_ff       <= val_in;
      key_ff       <= key_in;
      status_ff    <= status_in;
      pend_scan_ff <= pend_scan_in;
      pend_tag_ff  <= pend_tag_in;
      pend_oor_ff  <= pend_oor_in;
      vld_q_ff     <= vld_q_in;
      fv_ff        <= fv_in;
      root_ff      <= root_in;
      nz_ff        <= nz_in;
      last_ff      <= last_in;
      has_any_ff   <= has_any_in;
      m_any_ff     <= m_any_in;
      has_par_ff   <= has_par_in;
      m_par_ff     <= m_par_in;
      has_even_ff  <= has_even_in;
      m_even_ff    <= m_even_in;
      has_odd_ff   <= has_odd_in;
      m_odd_ff     <= m_odd_in;
      rsp_data_ff  <= rsp_data_in;
   end

   a_busy_after_beat: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("req_tready high right after an accepted beat");

   a_empty_matches_root: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata.tree_empty == (rsp_tdata.root_value == '0)))
      else $error("tree_empty disagrees with root_value");

   a_depth_matches_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata.tree_empty == (rsp_tdata.tree_depth == '0)))
      else $error("tree_depth disagrees with tree_empty");

   a_error_no_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata.status) |-> (rsp_tdata.read_value == '0))
      else $error("read_value set on an error beat");

endmodule

>>> rtl/core/abts_ram.sv
module abts_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 127
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/abts_fsm.sv
module abts_fsm (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_fire,
   input  abts_pkg::cmd_type req_cmd,
   input  abts_pkg::cmd_type cmd,
   input  logic              pos_ok,
   input  logic              rsp_free,
   output abts_pkg::ctl_type ctl
);
   import abts_pkg::*;

   state_type         state_ff, state_in;
   logic [SLOT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cnt_in = '0;
               case (req_cmd)
                  CMD_ASSIGN, CMD_READ: state_in = pos_ok ? ST_FETCH : ST_SCAN;
                  default:              state_in = ST_SCAN;
               endcase
            end
         end
         ST_FETCH: begin
            if (cnt_ff == fetch_last(cmd)) begin
               state_in = ST_FETCH_WAIT;
            end else begin
               cnt_in = cnt_ff + SLOT_W'(1);
            end
         end
         ST_FETCH_WAIT: begin
            cnt_in = '0;
            case (cmd)
               CMD_ASSIGN: state_in = ST_WRITE;
               CMD_FIND:   state_in = ST_DONE;
               default:    state_in = ST_SCAN;
            endcase
         end
         ST_WRITE: begin
            cnt_in   = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (cnt_ff == SLOT_W'(TREE_SLOTS - 1)) begin
               state_in = ST_SCAN_WAIT;
            end else begin
               cnt_in = cnt_ff + SLOT_W'(1);
            end
         end
         ST_SCAN_WAIT: begin
            cnt_in   = '0;
            state_in = (cmd == CMD_FIND) ? ST_FETCH : ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctl          = '0;
      ctl.tag      = cnt_ff;
      ctl.idle     = (state_ff == ST_IDLE);
      ctl.issue    = (state_ff == ST_FETCH) || (state_ff == ST_SCAN);
      ctl.scan     = (state_ff == ST_SCAN);
      ctl.write    = (state_ff == ST_WRITE);
      ctl.load_out = (state_ff == ST_DONE) && rsp_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule
